FILE: hdl/generational_handle_table_top_assert.svh
// Assertion macros for the generational handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every rising clock edge outside reset.
`define GHT_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("generational_handle_table: check failed");
// Check that a condition implies another in the same cycle.
`define GHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("generational_handle_table: implication failed");
`else
`define GHT_ASSERT(label, expr)
`define GHT_ASSERT_IMPL(label, ante, cons)
`endif
`endif

FILE: hdl/ght_pkg.sv
// Shared types, constants and helpers of the generational handle table.
package ght_pkg;

  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 12;
  localparam int GEN_W     = 32;
  localparam int POINTER_W = 64;
  localparam int LIVE_W    = 13;

  localparam int SLOTS_PER_PAGE_DEF = 256;
  localparam int PAGE_COUNT_DEF     = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam int IN_FIELDS_W  = SLOT_W + GEN_W + POINTER_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + SLOT_W + GEN_W + POINTER_W + LIVE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESOLVE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_REJECT,
    CMD_FREE,
    CMD_RESOLVE,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_W-1:0]      slot;
    logic [GEN_W-1:0]       gen;
    logic [POINTER_W-1:0]   ptr;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic clear_busy;
  } back_status_t;

  // Next generation, skipping zero on wrap.
  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    bump_gen = (g == '1) ? GEN_W'(1) : g + GEN_W'(1);
  endfunction

endpackage

FILE: hdl/generational_handle_table_top.sv
// Top level of the generational handle table.
// Handle table of SLOTS_PER_PAGE * PAGE_COUNT slots (4096 at the defaults). Each request
// beat on the slave side gives exactly one result beat on the master side, in order.
// In the back part, allocate, free and resolve each read the slot's generation/live
// word, pointer and free-list link from the slot memories in the issuing cycle; the
// cycle after writes back what changed and loads the result register. Clear walks the
// grown pages one slot per cycle through the generation memory's read and write ports.
// After reset, a clearing pass over all SLOTS_PER_PAGE * PAGE_COUNT slots (4096
// at the defaults) sets every generation to 1 and every live mark to 0;
// s_axis_tready stays low until it ends. A two-beat command queue between the front and
// back parts keeps input beats flowing while a finished result waits in the output
// register. A generation that is never issued (zero) matches no slot, generations wrap
// from all ones to 1, and a zero pointer makes allocate fail without side effects.
`include "generational_handle_table_top_assert.svh"

module generational_handle_table_top
  import ght_pkg::*;
#(
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF,
  parameter int PAGE_COUNT     = PAGE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // low bit up: slot_index[11:0], generation[43:12], pointer_value[107:44], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]: 0 allocate, 1 free, 2 resolve, 3 clear
  input  logic [REQ_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low bit up: ok[0], out_slot[12:1], out_generation[44:13], out_pointer[108:45],
  // live_total[121:109], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int TOTAL = SLOTS_PER_PAGE * PAGE_COUNT;

  back_status_t         status;
  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_pop;
  logic                 out_ok;
  logic [SLOT_W-1:0]    out_slot;
  logic [GEN_W-1:0]     out_gen;
  logic [POINTER_W-1:0] out_ptr;
  logic [LIVE_W-1:0]    live_total;

  // Front: decode the request kind, reject zero pointers early, queue the command.
  ght_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_axis_tvalid),
    .s_ready      (s_axis_tready),
    .req_type     (s_axis_tuser),
    .slot_index   (s_axis_tdata[SLOT_W-1:0]),
    .generation   (s_axis_tdata[SLOT_W+GEN_W-1:SLOT_W]),
    .pointer_value(s_axis_tdata[IN_FIELDS_W-1:SLOT_W+GEN_W]),
    .status       (status),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: run the command against the slot memories and free list, hold the result.
  ght_back #(
    .SLOTS_PER_PAGE(SLOTS_PER_PAGE),
    .PAGE_COUNT    (PAGE_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .status        (status),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .ok            (out_ok),
    .out_slot      (out_slot),
    .out_generation(out_gen),
    .out_pointer   (out_ptr),
    .live_total    (live_total)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                         live_total, out_ptr, out_gen, out_slot, out_ok};

  // A failed request carries zeros in every field but the live count.
  `GHT_ASSERT(a_fail_fields_zero, !(m_axis_tvalid && !out_ok) || (out_slot == '0 && out_gen == '0 && out_ptr == '0))
  // The live count never exceeds the capacity.
  `GHT_ASSERT(a_live_bound, !m_axis_tvalid || (32'(live_total) <= TOTAL))
  // No input beat is taken while the reset sweep runs.
  `GHT_ASSERT_IMPL(a_init_blocks_input, status.init_busy, !s_axis_tready)
  // The clear sweep starts only once the output register is empty.
  `GHT_ASSERT_IMPL(a_clear_no_result, status.clear_busy, !m_axis_tvalid)

endmodule

FILE: hdl/ght_ram.sv
// Generic simple dual-port RAM with registered read.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ght_fifo.sv
// Small command queue between the front and back parts.
module ght_fifo
  import ght_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int QP_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        entries[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == QP_W'(DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QP_W'(DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/ght_front.sv
// Front part: accept request beats, classify them and queue the commands.
module ght_front
  import ght_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [SLOT_W-1:0]    slot_index,
  input  logic [GEN_W-1:0]     generation,
  input  logic [POINTER_W-1:0] pointer_value,
  input  back_status_t         status,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t q_din;
  logic q_full;
  logic q_empty;

  always_comb begin
    q_din.slot = slot_index;
    q_din.gen  = generation;
    q_din.ptr  = pointer_value;
    case (req_t'(req_type))
      REQ_ALLOC:   q_din.kind = (pointer_value == '0) ? CMD_REJECT : CMD_ALLOC;
      REQ_FREE:    q_din.kind = CMD_FREE;
      REQ_RESOLVE: q_din.kind = CMD_RESOLVE;
      REQ_CLEAR:   q_din.kind = CMD_CLEAR;
      default:     q_din.kind = CMD_REJECT;
    endcase
  end

  // Hold off input while the back part sweeps the slot memories after reset.
  assign s_ready   = !q_full && !status.init_busy;
  assign cmd_valid = !q_empty;

  ght_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (s_valid && s_ready),
    .din  (q_din),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (cmd),
    .empty(q_empty)
  );

endmodule

FILE: hdl/ght_back.sv
// Back part: slot memories, free list, growth and the clear sweep.
module ght_back
  import ght_pkg::*;
#(
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF,
  parameter int PAGE_COUNT     = PAGE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  output back_status_t         status,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic                 ok,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [GEN_W-1:0]     out_generation,
  output logic [POINTER_W-1:0] out_pointer,
  output logic [LIVE_W-1:0]    live_total
);

  localparam int TOTAL  = SLOTS_PER_PAGE * PAGE_COUNT;
  localparam int IDX_W  = $clog2(TOTAL);
  localparam int CNT_W  = $clog2(TOTAL + 1);
  localparam int META_W = GEN_W + 1;
  localparam logic [CNT_W-1:0] EMPTY = CNT_W'(TOTAL);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_EXEC, ST_CLEAR} state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  cmd_t             cur;
  logic [IDX_W-1:0] cur_slot;
  logic             cur_from_list;
  logic             cur_got;
  logic [CNT_W-1:0] free_top;
  logic [CNT_W-1:0] fresh_next;
  logic [CNT_W-1:0] grown_limit;
  logic [CNT_W-1:0] live_count;

  logic              alloc_from_list;
  logic              alloc_fresh_ok;
  logic [IDX_W-1:0]  alloc_slot;
  logic              issue;
  logic [IDX_W-1:0]  raddr;
  logic [META_W-1:0] meta_rdata;
  logic [POINTER_W-1:0] ptr_rdata;
  logic [CNT_W-1:0]  link_rdata;
  logic              meta_live;
  logic [GEN_W-1:0]  meta_gen;
  logic              handle_ok;
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic              ptr_we;
  logic              link_we;
  logic              clear_last;

  assign alloc_from_list = (free_top < EMPTY);
  assign alloc_fresh_ok  = (fresh_next < EMPTY);
  assign alloc_slot      = alloc_from_list ? IDX_W'(free_top) : IDX_W'(fresh_next);
  assign issue   = (state == ST_IDLE) && cmd_valid && (!m_valid || m_ready);
  assign cmd_pop = issue;

  assign status.init_busy  = (state == ST_INIT);
  assign status.clear_busy = (state == ST_CLEAR);

  assign meta_live  = meta_rdata[GEN_W];
  assign meta_gen   = meta_rdata[GEN_W-1:0];
  assign handle_ok  = (32'(cur.slot) < 32'(grown_limit)) && meta_live &&
                      (meta_gen == cur.gen);
  assign clear_last = (32'(cnt) == 32'(grown_limit) - 32'd1);

  always_comb begin
    if (state == ST_CLEAR) begin
      raddr = cnt + IDX_W'(1);
    end else if (cmd.kind == CMD_ALLOC) begin
      raddr = alloc_slot;
    end else if (cmd.kind == CMD_CLEAR) begin
      raddr = '0;
    end else begin
      raddr = IDX_W'(cmd.slot);
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cnt;
    meta_wdata = {1'b0, GEN_W'(1)};
    ptr_we     = 1'b0;
    link_we    = 1'b0;
    case (state)
      ST_INIT: begin
        meta_we = 1'b1;
      end
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_wdata = {1'b0, bump_gen(meta_gen)};
      end
      ST_EXEC: begin
        if (cur.kind == CMD_ALLOC && cur_got) begin
          meta_we    = 1'b1;
          meta_waddr = cur_slot;
          meta_wdata = {1'b1, meta_gen};
          ptr_we     = 1'b1;
        end else if (cur.kind == CMD_FREE && handle_ok) begin
          meta_we    = 1'b1;
          meta_waddr = cur_slot;
          meta_wdata = {1'b0, bump_gen(meta_gen)};
          link_we    = 1'b1;
        end
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  ght_ram #(.WIDTH(META_W), .DEPTH(TOTAL)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(raddr), .rdata(meta_rdata)
  );

  ght_ram #(.WIDTH(POINTER_W), .DEPTH(TOTAL)) u_ptr_ram (
    .clk(clk), .we(ptr_we), .waddr(cur_slot), .wdata(cur.ptr),
    .raddr(raddr), .rdata(ptr_rdata)
  );

  ght_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(cur_slot), .wdata(free_top),
    .raddr(raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      free_top    <= EMPTY;
      fresh_next  <= '0;
      grown_limit <= CNT_W'(SLOTS_PER_PAGE);
      live_count  <= '0;
      m_valid     <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          cnt <= cnt + IDX_W'(1);
          if (32'(cnt) == TOTAL - 1) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (issue) begin
            cur           <= cmd;
            cur_from_list <= alloc_from_list;
            cur_got       <= alloc_from_list || alloc_fresh_ok;
            cur_slot      <= (cmd.kind == CMD_ALLOC) ? alloc_slot : IDX_W'(cmd.slot);
            cnt           <= '0;
            state         <= (cmd.kind == CMD_CLEAR) ? ST_CLEAR : ST_EXEC;
          end
        end
        ST_EXEC: begin
          state          <= ST_IDLE;
          m_valid        <= 1'b1;
          ok             <= 1'b0;
          out_slot       <= '0;
          out_generation <= '0;
          out_pointer    <= '0;
          live_total     <= LIVE_W'(live_count);
          case (cur.kind)
            CMD_ALLOC: begin
              if (cur_got) begin
                ok             <= 1'b1;
                out_slot       <= SLOT_W'(cur_slot);
                out_generation <= meta_gen;
                live_count     <= live_count + CNT_W'(1);
                live_total     <= LIVE_W'(live_count + CNT_W'(1));
                if (cur_from_list) begin
                  free_top <= (link_rdata > EMPTY) ? EMPTY : link_rdata;
                end else begin
                  fresh_next <= fresh_next + CNT_W'(1);
                  if (fresh_next >= grown_limit) begin
                    grown_limit <= grown_limit + CNT_W'(SLOTS_PER_PAGE);
                  end
                end
              end
            end
            CMD_FREE: begin
              if (handle_ok) begin
                ok       <= 1'b1;
                free_top <= CNT_W'(cur.slot);
                if (live_count != '0) begin
                  live_count <= live_count - CNT_W'(1);
                  live_total <= LIVE_W'(live_count - CNT_W'(1));
                end
              end
            end
            CMD_RESOLVE: begin
              if (handle_ok) begin
                ok          <= 1'b1;
                out_pointer <= ptr_rdata;
              end
            end
            default: begin
              ok <= 1'b0;
            end
          endcase
        end
        ST_CLEAR: begin
          cnt <= cnt + IDX_W'(1);
          if (clear_last) begin
            state          <= ST_IDLE;
            free_top       <= EMPTY;
            fresh_next     <= '0;
            live_count     <= '0;
            m_valid        <= 1'b1;
            ok             <= 1'b1;
            out_slot       <= '0;
            out_generation <= '0;
            out_pointer    <= '0;
            live_total     <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/handle_table_checker.sv
// Checker for the generational handle table: predicts every result beat and compares it.
module handle_table_checker
  import ght_pkg::*;
#(
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF,
  parameter int PAGE_COUNT     = PAGE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // low bit up: slot_index, generation, pointer_value, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [REQ_W-1:0]      s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low bit up: ok, out_slot, out_generation, out_pointer, live_total, zero pad
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count,
  output int                    pending_results
);

  localparam int TOTAL_SLOTS = SLOTS_PER_PAGE * PAGE_COUNT;

  typedef struct packed {
    logic [LIVE_W-1:0]    live;
    logic [POINTER_W-1:0] ptr;
    logic [GEN_W-1:0]     gen;
    logic [SLOT_W-1:0]    slot;
    logic                 ok;
  } outcome_t;

  // Shadow copy of the table.
  logic [GEN_W-1:0]     gen_of    [TOTAL_SLOTS];
  logic [POINTER_W-1:0] ptr_of    [TOTAL_SLOTS];
  logic [LIVE_W-1:0]    next_free [TOTAL_SLOTS];
  bit                   live_of   [TOTAL_SLOTS];
  int unsigned          free_head;
  int unsigned          fresh_slot;
  int unsigned          pages;
  int unsigned          live_now;

  outcome_t expected_q[$];
  outcome_t seen;
  outcome_t want;
  int       mismatches = 0;
  int       waiting = 0;

  assign fail_count      = mismatches;
  assign pending_results = waiting;

  function automatic logic [GEN_W-1:0] next_generation(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] bumped;
    bumped = g + GEN_W'(1);
    if (bumped == '0) bumped = GEN_W'(1);
    return bumped;
  endfunction

  function automatic bit handle_live(input logic [SLOT_W-1:0] slot,
                                     input logic [GEN_W-1:0] gen);
    int unsigned k;
    k = slot;
    if (k >= pages * SLOTS_PER_PAGE || k >= TOTAL_SLOTS) return 1'b0;
    return live_of[k] && gen_of[k] == gen;
  endfunction

  task automatic reset_table();
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      gen_of[i]    = GEN_W'(1);
      ptr_of[i]    = '0;
      next_free[i] = '0;
      live_of[i]   = 1'b0;
    end
    free_head  = TOTAL_SLOTS;
    fresh_slot = 0;
    pages      = 1;
    live_now   = 0;
  endtask

  task automatic apply_request(input req_t req, input logic [SLOT_W-1:0] slot,
                               input logic [GEN_W-1:0] gen,
                               input logic [POINTER_W-1:0] ptr, output outcome_t r);
    int unsigned pick;
    int unsigned span;
    bit          got;
    r    = '0;
    got  = 1'b0;
    pick = 0;
    span = pages * SLOTS_PER_PAGE;
    case (req)
      REQ_ALLOC: begin
        if (ptr != '0) begin
          if (free_head < TOTAL_SLOTS) begin
            pick      = free_head;
            free_head = next_free[pick];
            if (free_head > TOTAL_SLOTS) free_head = TOTAL_SLOTS;
            got = 1'b1;
          end else if (fresh_slot < TOTAL_SLOTS) begin
            if (fresh_slot >= span && pages < PAGE_COUNT) pages++;
            pick = fresh_slot;
            fresh_slot++;
            got = 1'b1;
          end
        end
        if (got) begin
          ptr_of[pick]  = ptr;
          live_of[pick] = 1'b1;
          live_now++;
          r.ok   = 1'b1;
          r.slot = SLOT_W'(pick);
          r.gen  = gen_of[pick];
        end
      end
      REQ_FREE: begin
        if (handle_live(slot, gen)) begin
          pick            = slot;
          ptr_of[pick]    = '0;
          gen_of[pick]    = next_generation(gen_of[pick]);
          live_of[pick]   = 1'b0;
          next_free[pick] = LIVE_W'(free_head);
          free_head       = pick;
          if (live_now > 0) live_now--;
          r.ok = 1'b1;
        end
      end
      REQ_RESOLVE: begin
        if (handle_live(slot, gen)) begin
          r.ok  = 1'b1;
          r.ptr = ptr_of[slot];
        end
      end
      default: begin
        if (span > TOTAL_SLOTS) span = TOTAL_SLOTS;
        for (int i = 0; i < span; i++) begin
          ptr_of[i]  = '0;
          gen_of[i]  = next_generation(gen_of[i]);
          live_of[i] = 1'b0;
        end
        free_head  = TOTAL_SLOTS;
        fresh_slot = 0;
        live_now   = 0;
        r.ok       = 1'b1;
      end
    endcase
    r.live = LIVE_W'(live_now);
  endtask

  task automatic check_field(input string label, input logic [POINTER_W-1:0] exp_val,
                             input logic [POINTER_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_table();
      expected_q.delete();
    end else begin
      // Compare the result beat first: it always belongs to an older request.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = outcome_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing actual %h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("ok", POINTER_W'(want.ok), POINTER_W'(seen.ok));
          check_field("out_slot", POINTER_W'(want.slot), POINTER_W'(seen.slot));
          check_field("out_generation", POINTER_W'(want.gen), POINTER_W'(seen.gen));
          check_field("out_pointer", want.ptr, seen.ptr);
          check_field("live_total", POINTER_W'(want.live), POINTER_W'(seen.live));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(req_t'(s_axis_tuser), s_axis_tdata[SLOT_W-1:0],
                      s_axis_tdata[SLOT_W+GEN_W-1:SLOT_W],
                      s_axis_tdata[IN_FIELDS_W-1:SLOT_W+GEN_W], want);
        expected_q.push_back(want);
      end
    end
    waiting = expected_q.size();
  end

endmodule

FILE: tb/sv/generational_handle_table_top_tb.sv
// Testbench top for the generational handle table: stimulus, handle pool and verdict.
module generational_handle_table_top_tb;
  import ght_pkg::*;

  localparam int TOTAL_SLOTS = SLOTS_PER_PAGE_DEF * PAGE_COUNT_DEF;
  localparam int RAND_ITEMS  = 1650;
  // Result beat layout: ok at bit 0, then slot, then generation.
  localparam int SLOT_LO     = 1;
  localparam int GEN_LO      = SLOT_LO + SLOT_W;
  localparam int DRAIN_WAIT  = 16;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // low bit up: slot_index[11:0], generation[43:12], pointer_value[107:44], zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // req_type[1:0]
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // low bit up: ok[0], out_slot[12:1], out_generation[44:13], out_pointer[108:45],
  // live_total[121:109], zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int      fail_count;
  int      pending_results;
  // Set to run a phase with no idling on either side.
  bit      quiet = 1'b0;
  // Handles handed out by allocate beats, used to build well-formed free and resolve.
  handle_t handle_pool[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  generational_handle_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  handle_table_checker table_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Collect handles from successful allocates; only allocate reports a nonzero generation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tdata[0] &&
        m_axis_tdata[GEN_LO+GEN_W-1:GEN_LO] != '0) begin
      handle_pool.push_back('{slot: m_axis_tdata[GEN_LO-1:SLOT_LO],
                              gen:  m_axis_tdata[GEN_LO+GEN_W-1:GEN_LO]});
    end
  end

  // Result side: hold tready low for a random stall before each beat.
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic logic [POINTER_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Drive one request beat after a random gap and hold it until it is accepted.
  task automatic issue_request(input req_t req, input logic [SLOT_W-1:0] slot,
                               input logic [GEN_W-1:0] gen,
                               input logic [POINTER_W-1:0] ptr);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= IN_DATA_W'({ptr, gen, slot});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Noise slot: half the time the first page, where live slots sit, else anywhere.
  function automatic logic [SLOT_W-1:0] noise_slot();
    return $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 255))
                                : SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
  endfunction

  function automatic logic [GEN_W-1:0] noise_gen();
    return $urandom_range(0, 1) ? GEN_W'($urandom_range(0, 3)) : GEN_W'($urandom);
  endfunction

  // One random request; weights are out of 1000, the rest of the range is clear.
  task automatic random_request(input int alloc_w, input int free_w, input int resolve_w);
    int unsigned      roll;
    int unsigned      k;
    handle_t          h;
    logic [POINTER_W-1:0] ptr;
    roll = $urandom_range(0, 999);
    if (roll < alloc_w) begin
      // Mostly live pointers, with an occasional zero pointer.
      ptr = ($urandom_range(0, 29) == 0) ? '0 : rand_word();
      issue_request(REQ_ALLOC, SLOT_W'($urandom), GEN_W'($urandom), ptr);
    end else if (roll < alloc_w + free_w) begin
      if (handle_pool.size() != 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, handle_pool.size() - 1);
        h = handle_pool[k];
        // Keep a few freed handles around to try a double free later.
        if ($urandom_range(0, 9) != 0) handle_pool.delete(k);
        issue_request(REQ_FREE, h.slot, h.gen, rand_word());
      end else begin
        issue_request(REQ_FREE, noise_slot(), noise_gen(), rand_word());
      end
    end else if (roll < alloc_w + free_w + resolve_w) begin
      roll = $urandom_range(0, 19);
      if (handle_pool.size() != 0 && roll < 14) begin
        h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
        issue_request(REQ_RESOLVE, h.slot, h.gen, rand_word());
      end else if (handle_pool.size() != 0 && roll < 17) begin
        // Right slot, one generation bit flipped.
        h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
        issue_request(REQ_RESOLVE, h.slot, h.gen ^ (GEN_W'(1) << $urandom_range(0, 31)),
                      rand_word());
      end else begin
        issue_request(REQ_RESOLVE, noise_slot(), noise_gen(), rand_word());
      end
    end else begin
      issue_request(REQ_CLEAR, SLOT_W'($urandom), GEN_W'($urandom), rand_word());
      // Mostly drop the dead handles; now and then keep them as stale noise.
      if ($urandom_range(0, 9) != 0) handle_pool.delete();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= REQ_ALLOC;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: zero pointer, field extremes, bad handles, LIFO reuse, clear.
    issue_request(REQ_ALLOC, '0, '0, '0);
    issue_request(REQ_ALLOC, '1, '1, '1);
    issue_request(REQ_ALLOC, '0, '0, POINTER_W'(1));
    issue_request(REQ_RESOLVE, SLOT_W'(0), GEN_W'(1), '0);
    // Generation zero is never issued.
    issue_request(REQ_RESOLVE, SLOT_W'(0), '0, '0);
    // Slot outside the grown page.
    issue_request(REQ_RESOLVE, '1, GEN_W'(1), '1);
    issue_request(REQ_FREE, SLOT_W'(0), '1, '0);
    issue_request(REQ_FREE, SLOT_W'(0), GEN_W'(1), '0);
    // Double free and resolve of a dead handle.
    issue_request(REQ_FREE, SLOT_W'(0), GEN_W'(1), '0);
    issue_request(REQ_RESOLVE, SLOT_W'(0), GEN_W'(2), '0);
    issue_request(REQ_ALLOC, '0, '0, {(POINTER_W/2){2'b01}});
    issue_request(REQ_FREE, SLOT_W'(1), GEN_W'(1), '0);
    issue_request(REQ_FREE, SLOT_W'(0), GEN_W'(2), '0);
    // Freed slots come back last in, first out.
    issue_request(REQ_ALLOC, '0, '0, {(POINTER_W/2){2'b10}});
    issue_request(REQ_ALLOC, '0, '0, POINTER_W'(1) << (POINTER_W - 1));
    issue_request(REQ_RESOLVE, SLOT_W'(2), GEN_W'(1), '0);
    issue_request(REQ_FREE, SLOT_W'(255), GEN_W'(1), '0);
    issue_request(REQ_CLEAR, '1, '1, '1);
    issue_request(REQ_RESOLVE, SLOT_W'(0), GEN_W'(3), '0);
    issue_request(REQ_ALLOC, '0, '0, rand_word() | POINTER_W'(1));
    issue_request(REQ_CLEAR, '0, '0, '0);
    handle_pool.delete();

    // Balanced traffic with occasional clears, full idling.
    repeat (RAND_ITEMS * 3 / 8) random_request(400, 250, 335);
    // Allocate-heavy, no clears, no idling: push past the first page.
    quiet = 1'b1;
    repeat (RAND_ITEMS * 3 / 8) random_request(600, 150, 250);
    quiet = 1'b0;

    // Churn on the grown pages, then clear every grown slot.
    repeat (RAND_ITEMS / 4) random_request(300, 300, 400);
    issue_request(REQ_CLEAR, SLOT_W'($urandom), GEN_W'($urandom), rand_word());
    handle_pool.delete();
    repeat (4) random_request(500, 250, 250);

    s_axis_tvalid <= 1'b0;
    // Drain: wait for every expected beat, then a short tail for stray beats.
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("generational_handle_table_top_tb passed");
    end else begin
      $display("generational_handle_table_top_tb failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is far shorter than this.
  initial begin
    #10_000_000;
    $display("generational_handle_table_top_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ght_pkg.sv
hdl/ght_ram.sv
hdl/ght_fifo.sv
hdl/ght_front.sv
hdl/ght_back.sv
hdl/generational_handle_table_top.sv
tb/sv/handle_table_checker.sv
tb/sv/generational_handle_table_top_tb.sv
